>>> rtl/htpe_pkg.sv
// ---------------------------------------------------------------------------
// htpe_pkg
// Shared types and constants for the haptic time pattern encoder.
// ---------------------------------------------------------------------------
package htpe_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_CLOCK_24H = 3'd1;
    localparam logic [2:0] CFG_LONG_MS   = 3'd2;
    localparam logic [2:0] CFG_SHORT_MS  = 3'd3;
    localparam logic [2:0] CFG_GAP_MS    = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // pattern modes
    localparam logic [1:0] PAT_TERSE  = 2'd0;
    localparam logic [1:0] PAT_DIGITS = 2'd1;
    localparam logic [1:0] PAT_MORSE  = 2'd2;
    localparam logic [1:0] PAT_SPARE  = 2'd3;   // unused code, decoded as terse

    localparam logic [15:0] RST_LONG_MS  = 16'd400;
    localparam logic [15:0] RST_SHORT_MS = 16'd150;
    localparam logic [15:0] RST_GAP_MS   = 16'd200;

    localparam int GROUP_COUNT = 4;
    localparam int VIBE_LIMIT  = 16;   // 31 segments per group at most
    localparam int MS_W        = 16;
    localparam int HOLD_W      = 11;
    localparam int ACC_W       = 21;   // 31 segments of 65535 ms

    // floor(x/1000) = (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 2^22
    localparam int               RECIP_W     = 22;
    localparam int               RECIP_SHIFT = 31;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 22'd2147484;
    localparam int               PROD_W      = ACC_W + RECIP_W;

    typedef struct packed {
        logic capture;      // latch the accepted time
        logic load;         // build group descriptors
        logic skip;         // move past an empty group slot
        logic grp_start;    // open the current group
        logic emit_gap;     // send a gap segment
        logic emit_vibe;    // send a vibe that is not the group's last
        logic latch_total;  // register group total before the hold divide
        logic mult;         // reciprocal multiply for the hold time
        logic emit_final;   // send the group's last vibe
    } t_cmd;

    typedef struct packed {
        logic slot_done;    // all group slots visited
        logic slot_valid;   // current slot holds vibes
        logic seg_gap;      // next segment is a gap
        logic seg_end;      // next vibe closes the group
        logic out_free;     // output register can take a transfer
    } t_status;

endpackage

>>> rtl/htpe_ctrl.sv
// ---------------------------------------------------------------------------
// htpe_ctrl
// Sequencer: walks group slots and segments, issues datapath commands.
// ---------------------------------------------------------------------------
module htpe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  htpe_pkg::t_status i_status,
    output htpe_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_SEG  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.slot_done) begin
                    n_state = ST_IDLE;
                end else if (i_status.slot_valid) begin
                    o_cmd.grp_start = 1'b1;
                    n_state         = ST_SEG;
                end else begin
                    o_cmd.skip = 1'b1;
                end
            end
            ST_SEG: begin
                if (i_status.seg_gap) begin
                    o_cmd.emit_gap = i_status.out_free;
                end else if (i_status.seg_end) begin
                    o_cmd.latch_total = 1'b1;
                    n_state           = ST_DIV;
                end else begin
                    o_cmd.emit_vibe = i_status.out_free;
                end
            end
            ST_DIV: begin
                o_cmd.mult = 1'b1;
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // an accepted item always starts a descriptor build
    a_capture_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_LOAD))
        else $error("capture not followed by load");

    // no segment is pushed into a full output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_gap || o_cmd.emit_vibe || o_cmd.emit_final) |-> i_status.out_free)
        else $error("segment emitted while output busy");

    // the hold multiply is always followed by the final vibe stage
    a_div_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |=> (r_state == ST_FIN))
        else $error("multiply stage not followed by final stage");

endmodule

>>> rtl/htpe_dp.sv
// ---------------------------------------------------------------------------
// htpe_dp
// Datapath: config registers, group descriptors, counters, hold-time
// multiply and the output register.
// ---------------------------------------------------------------------------
module htpe_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [htpe_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [htpe_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [4:0]                     i_hour,
    input  logic [5:0]                     i_minute,
    input  htpe_pkg::t_cmd                 i_cmd,
    output htpe_pkg::t_status              o_status,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [htpe_pkg::MS_W-1:0]      o_segment_ms,
    output logic                           o_motor_on,
    output logic [1:0]                     o_group_index,
    output logic                           o_group_end,
    output logic [htpe_pkg::HOLD_W-1:0]    o_hold_seconds,
    output logic                           o_last
);

    localparam int NW = $clog2(htpe_pkg::VIBE_LIMIT + 1);
    localparam int VW = $clog2(htpe_pkg::VIBE_LIMIT);

    // small constant divides by compare chains
    function automatic logic [2:0] f_div10(input logic [5:0] v);
        logic [2:0] q;
        if      (v >= 6'd50) q = 3'd5;
        else if (v >= 6'd40) q = 3'd4;
        else if (v >= 6'd30) q = 3'd3;
        else if (v >= 6'd20) q = 3'd2;
        else if (v >= 6'd10) q = 3'd1;
        else                 q = 3'd0;
        return q;
    endfunction

    function automatic logic [2:0] f_div5(input logic [4:0] v);
        logic [2:0] q;
        if      (v >= 5'd20) q = 3'd4;
        else if (v >= 5'd15) q = 3'd3;
        else if (v >= 5'd10) q = 3'd2;
        else if (v >= 5'd5)  q = 3'd1;
        else                 q = 3'd0;
        return q;
    endfunction

    function automatic logic [2:0] f_div15(input logic [5:0] v);
        logic [2:0] q;
        if      (v >= 6'd45) q = 3'd3;
        else if (v >= 6'd30) q = 3'd2;
        else if (v >= 6'd15) q = 3'd1;
        else                 q = 3'd0;
        return q;
    endfunction

    // bit i set = element i is a dash
    function automatic logic [4:0] f_morse(input logic [3:0] d);
        logic [4:0] m;
        case (d)
            4'd0:    m = 5'h1F;
            4'd1:    m = 5'h1E;
            4'd2:    m = 5'h1C;
            4'd3:    m = 5'h18;
            4'd4:    m = 5'h10;
            4'd5:    m = 5'h00;
            4'd6:    m = 5'h01;
            4'd7:    m = 5'h03;
            4'd8:    m = 5'h07;
            4'd9:    m = 5'h0F;
            default: m = 5'h00;
        endcase
        return m;
    endfunction

    function automatic logic [htpe_pkg::VIBE_LIMIT-1:0] f_ones(input logic [2:0] n);
        return (htpe_pkg::VIBE_LIMIT'(1) << n) - htpe_pkg::VIBE_LIMIT'(1);
    endfunction

    // config
    logic [1:0]                  r_mode;
    logic                        r_clock_24h;
    logic [htpe_pkg::MS_W-1:0]   r_long_ms, r_short_ms, r_gap_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= htpe_pkg::PAT_TERSE;
            r_clock_24h <= 1'b0;
            r_long_ms   <= htpe_pkg::RST_LONG_MS;
            r_short_ms  <= htpe_pkg::RST_SHORT_MS;
            r_gap_ms    <= htpe_pkg::RST_GAP_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                htpe_pkg::CFG_MODE:      r_mode      <= i_cfg_wdata[1:0];
                htpe_pkg::CFG_CLOCK_24H: r_clock_24h <= i_cfg_wdata[0];
                htpe_pkg::CFG_LONG_MS:   r_long_ms   <= i_cfg_wdata;
                htpe_pkg::CFG_SHORT_MS:  r_short_ms  <= i_cfg_wdata;
                htpe_pkg::CFG_GAP_MS:    r_gap_ms    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // time capture with range folding and 12h mapping
    logic [4:0] r_hour, n_hour;
    logic [5:0] r_min,  n_min;
    logic [4:0] w_h24;

    always_comb begin
        w_h24  = (i_hour >= 5'd24) ? i_hour - 5'd24 : i_hour;
        n_hour = w_h24;
        if (!r_clock_24h) begin
            n_hour = (w_h24 >= 5'd12) ? w_h24 - 5'd12 : w_h24;
            if (n_hour == 5'd0) n_hour = 5'd12;
        end
        n_min = (i_minute >= 6'd60) ? i_minute - 6'd60 : i_minute;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hour <= n_hour;
            r_min  <= n_min;
        end
    end

    // group descriptors: vibe count and dash mask per slot
    logic [NW-1:0]                   r_n    [htpe_pkg::GROUP_COUNT];
    logic [htpe_pkg::VIBE_LIMIT-1:0] r_mask [htpe_pkg::GROUP_COUNT];
    logic [NW-1:0]                   n_n    [htpe_pkg::GROUP_COUNT];
    logic [htpe_pkg::VIBE_LIMIT-1:0] n_mask [htpe_pkg::GROUP_COUNT];

    logic [2:0] w_hd10, w_md10, w_hd5, w_hr5, w_md15;
    logic [3:0] w_hr10, w_mr10;   // ones digit, up to 9

    always_comb begin
        w_hd10 = f_div10({1'b0, r_hour});
        w_hr10 = 4'(r_hour - 5'({w_hd10, 3'b000} + {1'b0, w_hd10, 1'b0}));
        w_md10 = f_div10(r_min);
        w_mr10 = 4'(r_min - 6'({w_md10, 3'b000} + {1'b0, w_md10, 1'b0}));
        w_hd5  = f_div5(r_hour);
        w_hr5  = 3'(r_hour - 5'({w_hd5, 2'b00} + {2'b00, w_hd5}));
        w_md15 = f_div15(r_min);
        for (int j = 0; j < htpe_pkg::GROUP_COUNT; j++) begin
            n_n[j]    = '0;
            n_mask[j] = '0;
        end
        case (r_mode)
            htpe_pkg::PAT_MORSE: begin
                if (r_hour >= 5'd10) begin
                    n_mask[0] = htpe_pkg::VIBE_LIMIT'(f_morse({1'b0, w_hd10}));
                    n_mask[1] = htpe_pkg::VIBE_LIMIT'(f_morse(w_hr10));
                    n_mask[2] = htpe_pkg::VIBE_LIMIT'(f_morse({1'b0, w_md10}));
                    n_mask[3] = htpe_pkg::VIBE_LIMIT'(f_morse(w_mr10));
                    for (int j = 0; j < 4; j++) n_n[j] = NW'(5);
                end else begin
                    n_mask[0] = htpe_pkg::VIBE_LIMIT'(f_morse(w_hr10));
                    n_mask[1] = htpe_pkg::VIBE_LIMIT'(f_morse({1'b0, w_md10}));
                    n_mask[2] = htpe_pkg::VIBE_LIMIT'(f_morse(w_mr10));
                    for (int j = 0; j < 3; j++) n_n[j] = NW'(5);
                end
            end
            htpe_pkg::PAT_DIGITS: begin
                n_n[0]    = NW'(w_hd10) + NW'(w_hr10);
                n_mask[0] = f_ones(w_hd10);
                n_n[1]    = NW'(w_md10) + NW'(w_mr10);
                n_mask[1] = f_ones(w_md10);
            end
            default: begin
                n_n[0]    = NW'(w_hd5) + NW'(w_hr5);
                n_mask[0] = f_ones(w_hd5);
                n_n[1]    = NW'(w_md15);
                n_mask[1] = f_ones(w_md15);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int j = 0; j < htpe_pkg::GROUP_COUNT; j++) begin
                r_n[j]    <= n_n[j];
                r_mask[j] <= n_mask[j];
            end
        end
    end

    // walk counters
    logic [2:0]                r_slot;     // msb set = all slots visited
    logic [VW-1:0]             r_vi;
    logic                      r_gap;
    logic [1:0]                r_grp;
    logic [htpe_pkg::ACC_W-1:0] r_acc;
    logic [htpe_pkg::ACC_W-1:0] r_total;
    logic [htpe_pkg::PROD_W-1:0] r_prod;

    logic [1:0]                 w_idx;
    logic [htpe_pkg::MS_W-1:0]  w_vibe;
    logic                       w_later;

    assign w_idx  = r_slot[1:0];
    assign w_vibe = r_mask[w_idx][r_vi] ? r_long_ms : r_short_ms;

    always_comb begin
        w_later = 1'b0;
        for (int j = 0; j < htpe_pkg::GROUP_COUNT; j++) begin
            if (2'(j) > w_idx && r_n[j] != '0) w_later = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_vi   <= '0;
            r_gap  <= 1'b0;
            r_grp  <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_slot <= '0;
                r_grp  <= '0;
            end
            if (i_cmd.skip || i_cmd.emit_final) r_slot <= r_slot + 3'd1;
            if (i_cmd.emit_final) r_grp <= r_grp + 2'd1;
            if (i_cmd.grp_start) begin
                r_vi  <= '0;
                r_gap <= 1'b0;
            end
            if (i_cmd.emit_vibe) begin
                r_vi  <= r_vi + VW'(1);
                r_gap <= 1'b1;
            end
            if (i_cmd.emit_gap) r_gap <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grp_start) r_acc <= '0;
        if (i_cmd.emit_gap)  r_acc <= r_acc + htpe_pkg::ACC_W'(r_gap_ms);
        if (i_cmd.emit_vibe) r_acc <= r_acc + htpe_pkg::ACC_W'(w_vibe);
        if (i_cmd.latch_total) r_total <= r_acc + htpe_pkg::ACC_W'(w_vibe);
        if (i_cmd.mult) begin
            r_prod <= htpe_pkg::PROD_W'(r_total) * htpe_pkg::PROD_W'(htpe_pkg::RECIP_1000);
        end
    end

    // output register
    logic out_free;
    assign out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit_gap || i_cmd.emit_vibe || i_cmd.emit_final) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_gap) begin
            o_segment_ms   <= r_gap_ms;
            o_motor_on     <= 1'b0;
            o_group_index  <= r_grp;
            o_group_end    <= 1'b0;
            o_hold_seconds <= '0;
            o_last         <= 1'b0;
        end else if (i_cmd.emit_vibe) begin
            o_segment_ms   <= w_vibe;
            o_motor_on     <= 1'b1;
            o_group_index  <= r_grp;
            o_group_end    <= 1'b0;
            o_hold_seconds <= '0;
            o_last         <= 1'b0;
        end else if (i_cmd.emit_final) begin
            o_segment_ms   <= w_vibe;
            o_motor_on     <= 1'b1;
            o_group_index  <= r_grp;
            o_group_end    <= 1'b1;
            o_hold_seconds <= r_prod[htpe_pkg::RECIP_SHIFT +: htpe_pkg::HOLD_W]
                              + htpe_pkg::HOLD_W'(1);
            o_last         <= !w_later;
        end
    end

    assign o_status.slot_done  = r_slot[2];
    assign o_status.slot_valid = (r_n[w_idx] != '0);
    assign o_status.seg_gap    = r_gap;
    assign o_status.seg_end    = ((NW'(r_vi) + NW'(1)) == r_n[w_idx]);
    assign o_status.out_free   = out_free;

    // a gap segment never closes a group
    a_gap_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_motor_on) |-> (!o_group_end && o_hold_seconds == '0))
        else $error("gap segment flagged as group end");

    // the last segment of an item is always a group end
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> o_group_end)
        else $error("last segment without group end");

endmodule

>>> rtl/haptic_time_pattern_encoder_core.sv
// ---------------------------------------------------------------------------
// haptic_time_pattern_encoder_core
// Turns an hour and minute into a stream of vibration-motor segments.
// ---------------------------------------------------------------------------
// One time request is taken at a time; the slave side is ready only while the
// block is idle. A request runs through capture and descriptor load, a scan
// step that skips each empty group slot, and for each group of vibes a scan
// step, the segments through the single output register (held while the
// consumer stalls), and a total latch and hold-time multiply before the
// group's closing vibe, then a final scan. Configuration goes through a plain
// write port and must only be written while the block is idle.
module haptic_time_pattern_encoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [htpe_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [htpe_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // time request
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // hour[4:0], minute[10:5]
    // segment stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // segment_ms[15:0],
                                                           // group_index[17:16],
                                                           // hold_seconds[28:18]
    output logic [1:0]                      m_axis_tuser,  // motor_on[0], group_end[1]
    output logic                            m_axis_tlast   // last segment of request
);

    htpe_pkg::t_cmd    w_cmd;
    htpe_pkg::t_status w_status;

    logic [htpe_pkg::MS_W-1:0]   w_segment_ms;
    logic                        w_motor_on;
    logic [1:0]                  w_group_index;
    logic                        w_group_end;
    logic [htpe_pkg::HOLD_W-1:0] w_hold_seconds;

    // sequencer: slot scan, segment walk, hold multiply
    htpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // config, descriptors, accumulator and output register
    htpe_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_hour         (s_axis_tdata[4:0]),
        .i_minute       (s_axis_tdata[10:5]),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_segment_ms   (w_segment_ms),
        .o_motor_on     (w_motor_on),
        .o_group_index  (w_group_index),
        .o_group_end    (w_group_end),
        .o_hold_seconds (w_hold_seconds),
        .o_last         (m_axis_tlast)
    );

    // pack the segment fields, zero fill to 32 bits
    assign m_axis_tdata = {3'b000, w_hold_seconds, w_group_index, w_segment_ms};
    assign m_axis_tuser = {w_group_end, w_motor_on};

endmodule
